// ----- src/ntaf_pkg.sv -----
// Shared types, codes and constants for the number-to-ASCII formatter.
`timescale 1ns / 1ps
package ntaf_pkg;

    localparam int VALUE_W        = 32;
    localparam int MAX_DEC_DIGITS = 9;
    localparam int MAX_BIN_DIGITS = 16;
    localparam int MAX_HEX_DIGITS = 8;

    localparam int BCD_DIGITS = 10;
    localparam int DATA_W     = BCD_DIGITS * 4;
    localparam int HEX_TOTAL  = VALUE_W / 4;
    localparam int SKIP_W     = $clog2(DATA_W);
    localparam int CONV_W     = $clog2(VALUE_W + 1);

    localparam logic [2:0] OP_BIN   = 3'd0;
    localparam logic [2:0] OP_UDEC  = 3'd1;
    localparam logic [2:0] OP_SDEC  = 3'd2;
    localparam logic [2:0] OP_HEX   = 3'd3;
    localparam logic [2:0] OP_HEX0X = 3'd4;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_UPA   = 7'h41;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_X     = 7'h78;

    localparam logic [3:0] DEC_SAT_DIGIT = 4'd9;
    localparam logic [3:0] HEX_TEN       = 4'd10;
    localparam logic [3:0] BCD_ADJ_MIN   = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [VALUE_W-1:0] value;
        logic               zero_fill;
        logic [4:0]         digit_count;
    } t_in_item;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last_char;
    } t_out_item;

    typedef enum logic [1:0] {
        MODE_BIN,
        MODE_DEC,
        MODE_HEX
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_ALIGN,
        S_PRE0,
        S_PRE1,
        S_DIGIT
    } t_state;

    // Control for the digit shift register
    typedef struct packed {
        logic load;
        logic align;
        logic shift;
        logic nibble;
        logic track_ovf;
    } t_sr_ctl;

endpackage

// ----- src/ntaf_bcd.sv -----
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
`timescale 1ns / 1ps
module ntaf_bcd (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic [ntaf_pkg::VALUE_W-1:0]      i_mag,
    output logic                              o_done,
    output logic [ntaf_pkg::DATA_W-1:0]       o_bcd
);

    logic [ntaf_pkg::VALUE_W-1:0] r_bin, n_bin;
    logic [ntaf_pkg::DATA_W-1:0]  r_bcd, n_bcd;
    logic [ntaf_pkg::DATA_W-1:0]  adj;
    logic [ntaf_pkg::CONV_W-1:0]  r_cnt, n_cnt;
    logic                         r_done, n_done;

    always_comb begin
        for (int k = 0; k < ntaf_pkg::BCD_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= ntaf_pkg::BCD_ADJ_MIN) begin
                adj[4*k +: 4] = r_bcd[4*k +: 4] + ntaf_pkg::BCD_ADJ_ADD;
            end else begin
                adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_load) begin
            n_bin = i_mag;
            n_bcd = '0;
            n_cnt = ntaf_pkg::CONV_W'(ntaf_pkg::VALUE_W);
        end else if (r_cnt != '0) begin
            // adjust every digit, then take in the next binary bit
            n_bcd  = {adj[ntaf_pkg::DATA_W-2:0], r_bin[ntaf_pkg::VALUE_W-1]};
            n_bin  = {r_bin[ntaf_pkg::VALUE_W-2:0], 1'b0};
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == ntaf_pkg::CONV_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// ----- src/ntaf_digit_sr.sv -----
// Digit shift register: skips unused high digits, flags decimal overflow, feeds digits out.
`timescale 1ns / 1ps
module ntaf_digit_sr (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ntaf_pkg::t_sr_ctl                i_ctl,
    input  logic [ntaf_pkg::DATA_W-1:0]      i_data,
    input  logic [ntaf_pkg::SKIP_W-1:0]      i_skip,
    output logic [3:0]                       o_top_nib,
    output logic                             o_top_bit,
    output logic                             o_skip_done,
    output logic                             o_ovf
);

    logic [ntaf_pkg::DATA_W-1:0] r_data, n_data;
    logic [ntaf_pkg::SKIP_W-1:0] r_skip, n_skip;
    logic                        r_ovf, n_ovf;
    logic [ntaf_pkg::DATA_W-1:0] shifted;

    assign o_top_nib   = r_data[ntaf_pkg::DATA_W-1 -: 4];
    assign o_top_bit   = r_data[ntaf_pkg::DATA_W-1];
    assign o_skip_done = (r_skip == '0);
    assign o_ovf       = r_ovf;

    always_comb begin
        if (i_ctl.nibble) begin
            shifted = {r_data[ntaf_pkg::DATA_W-5:0], 4'b0};
        end else begin
            shifted = {r_data[ntaf_pkg::DATA_W-2:0], 1'b0};
        end
    end

    always_comb begin
        n_data = r_data;
        n_skip = r_skip;
        n_ovf  = r_ovf;
        if (i_ctl.load) begin
            n_data = i_data;
            n_skip = i_skip;
            n_ovf  = 1'b0;
        end else if (i_ctl.align) begin
            // a non-zero digit above the shown ones means the value does not fit
            n_data = shifted;
            n_skip = r_skip - 1'b1;
            if (i_ctl.track_ovf && (o_top_nib != 4'b0)) begin
                n_ovf = 1'b1;
            end
        end else if (i_ctl.shift) begin
            n_data = shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_skip <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_skip <= n_skip;
            r_ovf  <= n_ovf;
        end
    end

endmodule

// ----- src/number_to_ascii_formatter.sv -----
// Top level of the number-to-ASCII formatter: item decode, sequencing and character output.
`timescale 1ns / 1ps
// Takes one item when start is high and busy is low, and emits its characters one per
// cycle on o_result, each marked by a one-cycle o_strobe, last_char set on the final one.
// The receiver cannot stall, so it must take a beat on every strobe. An item with an
// unknown opcode or an out-of-range digit count is taken and gives no characters.
// Binary and hex items pass an alignment shift over the unused high digits, then emit the
// prefix, if any, and the digits. Decimal items first pass a bit-serial binary-to-BCD
// conversion, then the digit-per-cycle alignment shift over the unused ones of the ten BCD
// digits, then emit the sign, if any, and the digits.
module number_to_ascii_formatter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  ntaf_pkg::t_in_item   i_item,
    output logic                 busy,
    output logic                 o_strobe,
    output ntaf_pkg::t_out_item  o_result
);

    ntaf_pkg::t_state r_state, n_state;
    ntaf_pkg::t_mode  r_mode, n_mode;
    logic             r_sign_pre, n_sign_pre;
    logic             r_hex_pre, n_hex_pre;
    logic             r_neg, n_neg;
    logic             r_shown, n_shown;
    logic [4:0]       r_left, n_left;
    logic             r_strobe, n_strobe;
    ntaf_pkg::t_out_item r_result, n_result;

    logic             accept;
    logic             item_ok;
    ntaf_pkg::t_mode  dec_mode;

    logic                              bcd_load;
    logic [ntaf_pkg::VALUE_W-1:0]      bcd_mag;
    logic                              bcd_done;
    logic [ntaf_pkg::DATA_W-1:0]       bcd_val;

    ntaf_pkg::t_sr_ctl                 sr_ctl;
    logic [ntaf_pkg::DATA_W-1:0]       sr_data;
    logic [ntaf_pkg::SKIP_W-1:0]       sr_skip;
    logic [3:0]                        sr_nib;
    logic                              sr_bit;
    logic                              sr_skip_done;
    logic                              sr_ovf;

    logic [3:0]                        dec_dig;
    logic [6:0]                        digit_char;
    logic                              dec_space;

    assign busy     = (r_state != ntaf_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    ntaf_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (bcd_load),
        .i_mag   (bcd_mag),
        .o_done  (bcd_done),
        .o_bcd   (bcd_val)
    );

    ntaf_digit_sr u_sr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (sr_ctl),
        .i_data      (sr_data),
        .i_skip      (sr_skip),
        .o_top_nib   (sr_nib),
        .o_top_bit   (sr_bit),
        .o_skip_done (sr_skip_done),
        .o_ovf       (sr_ovf)
    );

    // Item decode: format and digit-count range check
    always_comb begin
        dec_mode = ntaf_pkg::MODE_BIN;
        item_ok  = 1'b0;
        unique case (i_item.opcode) inside
            ntaf_pkg::OP_BIN: begin
                dec_mode = ntaf_pkg::MODE_BIN;
                item_ok  = (i_item.digit_count <= 5'(ntaf_pkg::MAX_BIN_DIGITS));
            end
            ntaf_pkg::OP_UDEC, ntaf_pkg::OP_SDEC: begin
                dec_mode = ntaf_pkg::MODE_DEC;
                item_ok  = (i_item.digit_count <= 5'(ntaf_pkg::MAX_DEC_DIGITS));
            end
            ntaf_pkg::OP_HEX, ntaf_pkg::OP_HEX0X: begin
                dec_mode = ntaf_pkg::MODE_HEX;
                item_ok  = (i_item.digit_count <= 5'(ntaf_pkg::MAX_HEX_DIGITS));
            end
            default: begin
                dec_mode = ntaf_pkg::MODE_BIN;
                item_ok  = 1'b0;
            end
        endcase
        if (i_item.digit_count == 5'd0) begin
            item_ok = 1'b0;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ntaf_pkg::S_IDLE: begin
                if (accept && item_ok) begin
                    n_state = (dec_mode == ntaf_pkg::MODE_DEC) ? ntaf_pkg::S_CONV
                                                              : ntaf_pkg::S_ALIGN;
                end
            end
            ntaf_pkg::S_CONV: begin
                if (bcd_done) begin
                    n_state = ntaf_pkg::S_ALIGN;
                end
            end
            ntaf_pkg::S_ALIGN: begin
                if (sr_skip_done) begin
                    n_state = (r_sign_pre || r_hex_pre) ? ntaf_pkg::S_PRE0
                                                        : ntaf_pkg::S_DIGIT;
                end
            end
            ntaf_pkg::S_PRE0: begin
                n_state = r_hex_pre ? ntaf_pkg::S_PRE1 : ntaf_pkg::S_DIGIT;
            end
            ntaf_pkg::S_PRE1: begin
                n_state = ntaf_pkg::S_DIGIT;
            end
            ntaf_pkg::S_DIGIT: begin
                if (r_left == 5'd1) begin
                    n_state = ntaf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ntaf_pkg::S_IDLE;
            end
        endcase
    end

    // Character for the digit at the top of the shift register
    always_comb begin
        dec_dig   = sr_ovf ? ntaf_pkg::DEC_SAT_DIGIT : sr_nib;
        dec_space = !r_shown && (dec_dig == 4'd0) && (r_left != 5'd1);
        case (r_mode)
            ntaf_pkg::MODE_BIN: begin
                digit_char = ntaf_pkg::CH_ZERO + 7'(sr_bit);
            end
            ntaf_pkg::MODE_HEX: begin
                if (sr_nib < ntaf_pkg::HEX_TEN) begin
                    digit_char = ntaf_pkg::CH_ZERO + 7'(sr_nib);
                end else begin
                    digit_char = ntaf_pkg::CH_UPA + 7'(sr_nib - ntaf_pkg::HEX_TEN);
                end
            end
            default: begin
                digit_char = dec_space ? ntaf_pkg::CH_SPACE
                                       : ntaf_pkg::CH_ZERO + 7'(dec_dig);
            end
        endcase
    end

    // Outputs and datapath control
    always_comb begin
        n_mode     = r_mode;
        n_sign_pre = r_sign_pre;
        n_hex_pre  = r_hex_pre;
        n_neg      = r_neg;
        n_shown    = r_shown;
        n_left     = r_left;
        n_strobe   = 1'b0;
        n_result   = r_result;
        bcd_load   = 1'b0;
        bcd_mag    = i_item.value;
        sr_data    = {i_item.value, (ntaf_pkg::DATA_W - ntaf_pkg::VALUE_W)'(0)};
        sr_skip    = '0;
        sr_ctl     = '0;
        sr_ctl.nibble    = (r_mode != ntaf_pkg::MODE_BIN);
        sr_ctl.track_ovf = (r_mode == ntaf_pkg::MODE_DEC);

        unique case (r_state)
            ntaf_pkg::S_IDLE: begin
                if (accept && item_ok) begin
                    n_mode     = dec_mode;
                    n_sign_pre = (i_item.opcode == ntaf_pkg::OP_SDEC);
                    n_hex_pre  = (i_item.opcode == ntaf_pkg::OP_HEX0X);
                    n_neg      = (i_item.opcode == ntaf_pkg::OP_SDEC)
                                 && i_item.value[ntaf_pkg::VALUE_W-1];
                    n_shown    = i_item.zero_fill;
                    n_left     = i_item.digit_count;
                    if (n_neg) begin
                        bcd_mag = ~i_item.value + ntaf_pkg::VALUE_W'(1);
                    end
                    bcd_load = (dec_mode == ntaf_pkg::MODE_DEC);
                    sr_ctl.load = (dec_mode != ntaf_pkg::MODE_DEC);
                    if (dec_mode == ntaf_pkg::MODE_BIN) begin
                        sr_skip = ntaf_pkg::SKIP_W'(ntaf_pkg::VALUE_W)
                                  - ntaf_pkg::SKIP_W'(i_item.digit_count);
                    end else begin
                        sr_skip = ntaf_pkg::SKIP_W'(ntaf_pkg::HEX_TOTAL)
                                  - ntaf_pkg::SKIP_W'(i_item.digit_count);
                    end
                end
            end
            ntaf_pkg::S_CONV: begin
                sr_data     = bcd_val;
                sr_skip     = ntaf_pkg::SKIP_W'(ntaf_pkg::BCD_DIGITS)
                              - ntaf_pkg::SKIP_W'(r_left);
                sr_ctl.load = bcd_done;
            end
            ntaf_pkg::S_ALIGN: begin
                sr_ctl.align = !sr_skip_done;
            end
            ntaf_pkg::S_PRE0: begin
                n_strobe = 1'b1;
                n_result.last_char = 1'b0;
                if (r_sign_pre) begin
                    n_result.char_code = r_neg ? ntaf_pkg::CH_MINUS : ntaf_pkg::CH_PLUS;
                end else begin
                    n_result.char_code = ntaf_pkg::CH_ZERO;
                end
            end
            ntaf_pkg::S_PRE1: begin
                n_strobe = 1'b1;
                n_result.last_char = 1'b0;
                n_result.char_code = ntaf_pkg::CH_X;
            end
            ntaf_pkg::S_DIGIT: begin
                n_strobe = 1'b1;
                n_result.char_code = digit_char;
                n_result.last_char = (r_left == 5'd1);
                sr_ctl.shift = 1'b1;
                n_left = r_left - 5'd1;
                if (!dec_space) begin
                    n_shown = 1'b1;
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_sign_pre <= n_sign_pre;
        r_hex_pre  <= n_hex_pre;
        r_neg      <= n_neg;
        r_shown    <= n_shown;
        r_result   <= n_result;
        if (!i_rst_n) begin
            r_state  <= ntaf_pkg::S_IDLE;
            r_left   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_left   <= n_left;
            r_strobe <= n_strobe;
        end
    end

    // A beat only follows a cycle that produced a character
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == ntaf_pkg::S_PRE0 || $past(r_state) == ntaf_pkg::S_PRE1
                      || $past(r_state) == ntaf_pkg::S_DIGIT))
        else $error("strobe without a character source");

    // The final beat of an item leaves the block free
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_char) |-> !busy)
        else $error("block still busy after last character");

    // Digits are only emitted while some remain
    a_left_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ntaf_pkg::S_DIGIT) |-> (r_left != 5'd0))
        else $error("digit state with no digits left");

    // Conversion only runs for decimal items
    a_conv_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ntaf_pkg::S_CONV) |-> (r_mode == ntaf_pkg::MODE_DEC))
        else $error("BCD conversion for a non-decimal item");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for number_to_ascii_formatter: directed and random items.
`timescale 1ns / 1ps
module tb;

    localparam int         TAIL_CYCLES   = 60;
    localparam int         CYCLE_LIMIT   = 300000;
    localparam int         RANDOM_ITEMS  = 102;
    localparam int         MAX_REPORTS   = 10;
    localparam logic [2:0] OP_BAD_FIRST  = 3'd5;
    localparam logic [2:0] OP_BAD_LAST   = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                start;
    ntaf_pkg::t_in_item  item;
    logic                busy;
    logic                strobe;
    ntaf_pkg::t_out_item result;

    ntaf_pkg::t_out_item pending_chars[$];
    int                  mismatch_count;
    int                  cycle_count;
    int                  idle_pct;

    number_to_ascii_formatter dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .start    (start),
        .i_item   (item),
        .busy     (busy),
        .o_strobe (strobe),
        .o_result (result)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL number_to_ascii_formatter");
            $finish;
        end
    end

    // Work out the characters of one item and queue them; returns how many.
    function automatic int queue_chars(input ntaf_pkg::t_in_item it);
        logic [6:0]          txt[$];
        logic [3:0]          digs [ntaf_pkg::MAX_DEC_DIGITS];
        logic [31:0]         mag;
        logic [3:0]          nib;
        longint unsigned     limit;
        logic                shown;
        int                  d;
        int                  k;
        ntaf_pkg::t_out_item ch;
        d = int'(it.digit_count);
        if (d != 0) begin
            case (it.opcode) inside
                ntaf_pkg::OP_BIN: begin
                    if (d <= ntaf_pkg::MAX_BIN_DIGITS) begin
                        for (k = d - 1; k >= 0; k--)
                            txt.push_back(ntaf_pkg::CH_ZERO + 7'(it.value[k]));
                    end
                end
                ntaf_pkg::OP_UDEC, ntaf_pkg::OP_SDEC: begin
                    if (d <= ntaf_pkg::MAX_DEC_DIGITS) begin
                        mag = it.value;
                        if (it.opcode == ntaf_pkg::OP_SDEC) begin
                            if (it.value[ntaf_pkg::VALUE_W-1]) begin
                                txt.push_back(ntaf_pkg::CH_MINUS);
                                mag = 32'd0 - it.value;
                            end else begin
                                txt.push_back(ntaf_pkg::CH_PLUS);
                            end
                        end
                        limit = 1;
                        for (k = 0; k < d; k++)
                            limit = limit * 10;
                        if (64'(mag) >= limit) begin
                            for (k = 0; k < d; k++)
                                digs[k] = ntaf_pkg::DEC_SAT_DIGIT;
                        end else begin
                            for (k = d - 1; k >= 0; k--) begin
                                digs[k] = 4'(mag % 10);
                                mag = mag / 10;
                            end
                        end
                        shown = it.zero_fill;
                        for (k = 0; k < d; k++) begin
                            if (!shown && digs[k] == 4'd0 && k != d - 1) begin
                                txt.push_back(ntaf_pkg::CH_SPACE);
                            end else begin
                                shown = 1'b1;
                                txt.push_back(ntaf_pkg::CH_ZERO + 7'(digs[k]));
                            end
                        end
                    end
                end
                ntaf_pkg::OP_HEX, ntaf_pkg::OP_HEX0X: begin
                    if (d <= ntaf_pkg::MAX_HEX_DIGITS) begin
                        if (it.opcode == ntaf_pkg::OP_HEX0X) begin
                            txt.push_back(ntaf_pkg::CH_ZERO);
                            txt.push_back(ntaf_pkg::CH_X);
                        end
                        for (k = d - 1; k >= 0; k--) begin
                            nib = it.value[4*k +: 4];
                            if (nib < ntaf_pkg::HEX_TEN)
                                txt.push_back(ntaf_pkg::CH_ZERO + 7'(nib));
                            else
                                txt.push_back(ntaf_pkg::CH_UPA
                                              + 7'(nib - ntaf_pkg::HEX_TEN));
                        end
                    end
                end
                default: ;
            endcase
        end
        for (k = 0; k < txt.size(); k++) begin
            ch.char_code = txt[k];
            ch.last_char = (k == txt.size() - 1);
            pending_chars.push_back(ch);
        end
        return txt.size();
    endfunction

    function automatic ntaf_pkg::t_in_item make_item(input logic [2:0] op,
                                                     input logic [31:0] v,
                                                     input logic zf, input logic [4:0] d);
        ntaf_pkg::t_in_item it;
        it.opcode      = op;
        it.value       = v;
        it.zero_fill   = zf;
        it.digit_count = d;
        return it;
    endfunction

    function automatic ntaf_pkg::t_in_item random_item();
        ntaf_pkg::t_in_item it;
        longint unsigned    p;
        int                 max_d;
        if ($urandom_range(99) < 90)
            it.opcode = 3'($urandom_range(ntaf_pkg::OP_HEX0X, ntaf_pkg::OP_BIN));
        else
            it.opcode = 3'($urandom_range(OP_BAD_LAST, OP_BAD_FIRST));
        case ($urandom_range(4))
            0: it.value = $urandom;
            1: it.value = $urandom_range(99);
            2: begin
                // land on either side of a power of ten
                p = 1;
                repeat ($urandom_range(9)) p = p * 10;
                it.value = 32'(p) + 32'($urandom_range(2)) - 32'd1;
            end
            3: begin
                case ($urandom_range(2))
                    0: it.value = 32'h8000_0000 + 32'($urandom_range(3));
                    1: it.value = 32'h7FFF_FFFF - 32'($urandom_range(3));
                    default: it.value = 32'd0 - 32'($urandom_range(1000));
                endcase
            end
            default: it.value = $urandom >> $urandom_range(31);
        endcase
        it.zero_fill = 1'($urandom_range(1));
        case (it.opcode) inside
            ntaf_pkg::OP_BIN:                     max_d = ntaf_pkg::MAX_BIN_DIGITS;
            ntaf_pkg::OP_UDEC, ntaf_pkg::OP_SDEC: max_d = ntaf_pkg::MAX_DEC_DIGITS;
            default:                              max_d = ntaf_pkg::MAX_HEX_DIGITS;
        endcase
        if ($urandom_range(99) < 85)
            it.digit_count = 5'($urandom_range(max_d, 1));
        else
            it.digit_count = 5'($urandom_range(31));
        return it;
    endfunction

    // Offer one item, hold it until taken, then queue its characters.
    task automatic send_item(input ntaf_pkg::t_in_item it, output int n_chars);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        n_chars = queue_chars(it);
    endtask

    always @(posedge clk) begin
        if (rst_n && strobe) begin
            if (pending_chars.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected beat: char %h last %b",
                             result.char_code, result.last_char);
                mismatch_count <= mismatch_count + 1;
            end else if (result !== pending_chars[0]) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("mismatch: expected char %h last %b, got char %h last %b",
                             pending_chars[0].char_code, pending_chars[0].last_char,
                             result.char_code, result.last_char);
                mismatch_count <= mismatch_count + 1;
                void'(pending_chars.pop_front());
            end else begin
                void'(pending_chars.pop_front());
            end
        end
    end

    task automatic test_directed();
        int n;
        idle_pct = 21;
        send_item(make_item(ntaf_pkg::OP_BIN,   32'h0000_FFFF, 1'b0, 5'd16), n);
        send_item(make_item(ntaf_pkg::OP_BIN,   32'hAAAA_5555, 1'b1, 5'd16), n);
        send_item(make_item(ntaf_pkg::OP_BIN,   32'h0000_0002, 1'b0, 5'd1),  n);
        send_item(make_item(ntaf_pkg::OP_BIN,   32'hFFFF_FFFF, 1'b0, 5'd17), n);
        send_item(make_item(ntaf_pkg::OP_BIN,   32'hFFFF_FFFF, 1'b0, 5'd0),  n);
        send_item(make_item(ntaf_pkg::OP_UDEC,  32'd0,         1'b0, 5'd1),  n);
        send_item(make_item(ntaf_pkg::OP_UDEC,  32'd0,         1'b0, 5'd9),  n);
        send_item(make_item(ntaf_pkg::OP_UDEC,  32'd42,        1'b1, 5'd5),  n);
        send_item(make_item(ntaf_pkg::OP_UDEC,  32'd42,        1'b0, 5'd5),  n);
        send_item(make_item(ntaf_pkg::OP_UDEC,  32'd999999999, 1'b0, 5'd9),  n);
        send_item(make_item(ntaf_pkg::OP_UDEC,  32'd1000000000, 1'b0, 5'd9), n);
        send_item(make_item(ntaf_pkg::OP_UDEC,  32'hFFFF_FFFF, 1'b1, 5'd9),  n);
        send_item(make_item(ntaf_pkg::OP_UDEC,  32'd7,         1'b0, 5'd31), n);
        send_item(make_item(ntaf_pkg::OP_SDEC,  32'h8000_0000, 1'b0, 5'd9),  n);
        send_item(make_item(ntaf_pkg::OP_SDEC,  32'hFFFF_FFFB, 1'b0, 5'd3),  n);
        send_item(make_item(ntaf_pkg::OP_SDEC,  32'h7FFF_FFFF, 1'b1, 5'd9),  n);
        send_item(make_item(ntaf_pkg::OP_SDEC,  32'd0,         1'b0, 5'd1),  n);
        send_item(make_item(ntaf_pkg::OP_SDEC,  32'd100,       1'b0, 5'd2),  n);
        send_item(make_item(ntaf_pkg::OP_HEX,   32'hDEAD_BEEF, 1'b0, 5'd8),  n);
        send_item(make_item(ntaf_pkg::OP_HEX,   32'h0123_ABCD, 1'b1, 5'd8),  n);
        send_item(make_item(ntaf_pkg::OP_HEX,   32'h0123_ABCD, 1'b0, 5'd9),  n);
        send_item(make_item(ntaf_pkg::OP_HEX0X, 32'h0000_ABCD, 1'b0, 5'd4),  n);
        send_item(make_item(ntaf_pkg::OP_HEX0X, 32'hFFFF_FFFF, 1'b1, 5'd1),  n);
        for (int op = OP_BAD_FIRST; op <= OP_BAD_LAST; op++)
            send_item(make_item(3'(op), 32'h1234_5678, 1'b1, 5'd4), n);
    endtask

    // Send a fixed number of random items at the given idle rate.
    task automatic run_random(input int pct);
        int n;
        idle_pct = pct;
        repeat (RANDOM_ITEMS)
            send_item(random_item(), n);
    endtask

    task automatic test_random_sender_busy();
        run_random(21);
    endtask

    task automatic test_random_sender_lazy();
        run_random(51);
    endtask

    task automatic test_random_back_to_back();
        run_random(0);
    endtask

    initial begin
        mismatch_count = 0;
        cycle_count    = 0;
        idle_pct       = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        item  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_sender_busy();
        test_random_sender_lazy();
        test_random_back_to_back();
        start <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("PASS number_to_ascii_formatter");
        end else begin
            $display("FAIL number_to_ascii_formatter");
        end
        $finish;
    end

endmodule
